// ===== src/cad_pkg.sv =====
// ----------------------------------------------------------------------------
// Crank angle decoder package
// Shared widths, angle constants and the state type of the sequencer.
// ----------------------------------------------------------------------------
package cad_pkg;

    localparam int TIME_BITS     = 32;
    localparam int TEETH_PER_REV = 36;
    localparam int ANGLE_BITS    = 20;
    localparam int SPAN_BITS     = 13;
    localparam int PROD_BITS     = TIME_BITS + SPAN_BITS;
    localparam int QUO_BITS      = ANGLE_BITS + 1;
    localparam int CNT_BITS      = $clog2(QUO_BITS);
    localparam int TOOTH_BITS    = 6;
    localparam int COIL_COUNT    = 4;

    localparam logic [SPAN_BITS-1:0]  HALF_SPAN  = SPAN_BITS'(5000);
    localparam logic [QUO_BITS-1:0]   TOOTH_SPAN = QUO_BITS'(10000);
    localparam logic [QUO_BITS-1:0]   REV_SPAN   = QUO_BITS'(TEETH_PER_REV * 10000);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX  = '1;

    localparam logic [ANGLE_BITS-1:0] WIN_ONE_HI   = ANGLE_BITS'(5000);
    localparam logic [ANGLE_BITS-1:0] WIN_TWO_LO   = ANGLE_BITS'(540000);
    localparam logic [ANGLE_BITS-1:0] WIN_TWO_HI   = ANGLE_BITS'(545000);
    localparam logic [ANGLE_BITS-1:0] WIN_THREE_LO = ANGLE_BITS'(180000);
    localparam logic [ANGLE_BITS-1:0] WIN_THREE_HI = ANGLE_BITS'(185000);
    localparam logic [ANGLE_BITS-1:0] WIN_FOUR_LO  = ANGLE_BITS'(360000);
    localparam logic [ANGLE_BITS-1:0] WIN_FOUR_HI  = ANGLE_BITS'(365000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_SUM,
        ST_WIN,
        ST_FIN
    } t_state;

    typedef logic [COIL_COUNT-1:0] t_coils;

    // Angle at the start of the given tooth within the 720 degree cycle.
    function automatic logic [QUO_BITS-1:0] base_angle(
        input logic                  half,
        input logic [TOOTH_BITS-1:0] tooth
    );
        logic [QUO_BITS-1:0] rev;
        logic [QUO_BITS-1:0] teeth;
        rev   = half ? REV_SPAN : '0;
        teeth = QUO_BITS'(QUO_BITS'(tooth) * TOOTH_SPAN);
        return rev + teeth;
    endfunction

endpackage

// ===== src/cad_if.sv =====
// ----------------------------------------------------------------------------
// Crank angle decoder channels
// Sample channel and result channel, each with valid, ready and a word.
// ----------------------------------------------------------------------------
interface cad_in_if;
    import cad_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] sample_time;
    logic                 sensor_level;

    modport source (output valid, output sample_time, output sensor_level, input ready);
    modport sink   (input valid, input sample_time, input sensor_level, output ready);
endinterface

interface cad_out_if;
    import cad_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;
    logic                  coil_one;
    logic                  coil_two;
    logic                  coil_three;
    logic                  coil_four;
    logic                  locked;
    logic                  zero_marker;

    modport source (
        output valid, output angle, output coil_one, output coil_two,
        output coil_three, output coil_four, output locked, output zero_marker,
        input  ready
    );
    modport sink (
        input  valid, input angle, input coil_one, input coil_two,
        input  coil_three, input coil_four, input locked, input zero_marker,
        output ready
    );
endinterface

// ===== src/cad_div.sv =====
// ----------------------------------------------------------------------------
// Crank angle decoder divider
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module cad_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cad_pkg::PROD_BITS-1:0] i_dividend,
    input  logic [cad_pkg::TIME_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [cad_pkg::QUO_BITS-1:0]  o_quotient
);
    import cad_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [TIME_BITS-1:0]  r_rem;
    logic [QUO_BITS-1:0]   r_low;
    logic [QUO_BITS-1:0]   r_quo;
    logic [TIME_BITS-1:0]  r_den;

    logic [TIME_BITS:0]    hi_part;
    logic [TIME_BITS:0]    rem_shift;
    logic [TIME_BITS-1:0]  rem_diff;
    logic                  quo_bit;

    assign hi_part   = (TIME_BITS + 1)'(i_dividend[PROD_BITS-1:QUO_BITS]);
    assign rem_shift = {r_rem, r_low[QUO_BITS-1]};
    assign rem_diff  = rem_shift[TIME_BITS-1:0] - r_den;
    assign quo_bit   = (rem_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_divisor == '0) begin
                    r_done <= 1'b1;
                end else if (hi_part >= {1'b0, i_divisor}) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= hi_part[TIME_BITS-1:0];
            r_low <= i_dividend[QUO_BITS-1:0];
            if (i_divisor == '0) begin
                r_quo <= '0;
            end else if (hi_part >= {1'b0, i_divisor}) begin
                r_quo <= '1;
            end else begin
                r_quo <= '0;
            end
        end else if (r_busy) begin
            r_rem <= quo_bit ? rem_diff : rem_shift[TIME_BITS-1:0];
            r_low <= {r_low[QUO_BITS-2:0], 1'b0};
            r_quo <= {r_quo[QUO_BITS-2:0], quo_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/cad_win.sv =====
// ----------------------------------------------------------------------------
// Crank angle decoder coil windows
// Decodes the four ignition coil windows from the crank angle.
// ----------------------------------------------------------------------------
module cad_win (
    input  logic [cad_pkg::ANGLE_BITS-1:0] i_angle,
    output cad_pkg::t_coils                o_coils
);
    import cad_pkg::*;

    always_comb begin
        o_coils    = '0;
        o_coils[0] = (i_angle <= WIN_ONE_HI);
        o_coils[1] = (i_angle >= WIN_TWO_LO) && (i_angle <= WIN_TWO_HI);
        o_coils[2] = (i_angle >= WIN_THREE_LO) && (i_angle <= WIN_THREE_HI);
        o_coils[3] = (i_angle >= WIN_FOUR_LO) && (i_angle <= WIN_FOUR_HI);
    end

endmodule

// ===== src/crank_angle_decoder_ignition.sv =====
// ----------------------------------------------------------------------------
// Crank angle decoder with ignition windows
// Missing-tooth trigger decoder with angle interpolation and coil windows.
//
// The sample channel takes one word per sensor sample: a microsecond time
// and the sensor level. The result channel gives one word per sample: the
// angle in thousandths of a degree over the 720 degree cycle, four coil
// window bits, the lock flag and a marker for angle zero.
// A sample is taken only while the sequencer is idle. A sample before lock
// passes through the evaluate and finish states to the result register, a
// sample with an edge after lock through evaluate, window and finish. A
// sample between edges after lock is interpolated: a multiply state and a
// load state, then the restoring divider, which yields one quotient bit per
// cycle; a zero or overflowing ratio finishes the divider at once. The sum,
// window and finish states follow. The sequencer returns to idle as the
// result register loads, so a new sample waits until the last one is done.
// The result sits in an output register; a new sample is accepted while it
// waits, and the sequencer holds its finished result until that register is
// free. Reset clears the lock, the tooth count, the stored edge times, the
// angle and the coils, and empties the output register.
// ----------------------------------------------------------------------------
module crank_angle_decoder_ignition (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cad_in_if.sink    i_smp,
    cad_out_if.source o_res
);
    import cad_pkg::*;

    t_state r_state;
    t_state n_state;

    logic                  r_locked;
    logic                  r_last;
    logic [TOOTH_BITS-1:0] r_tooth;
    logic                  r_half;
    logic [TIME_BITS-1:0]  r_rise;
    logic [TIME_BITS-1:0]  r_fall;
    logic [ANGLE_BITS-1:0] r_angle;
    t_coils                r_coil;
    logic                  r_marker;

    logic [TIME_BITS-1:0]  r_now;
    logic                  r_lvl;
    logic [TIME_BITS-1:0]  r_num;
    logic [TIME_BITS-1:0]  r_den;
    logic [QUO_BITS-1:0]   r_base;
    logic [PROD_BITS-1:0]  r_prod;

    logic                  r_out_valid;
    logic [ANGLE_BITS-1:0] r_out_angle;
    t_coils                r_out_coil;
    logic                  r_out_locked;
    logic                  r_out_marker;

    logic                  fall_edge;
    logic                  rise_edge;
    logic [TOOTH_BITS-1:0] tooth_inc;
    logic                  tooth_wrap;
    logic [TOOTH_BITS-1:0] tooth_next;
    logic                  half_next;
    logic [QUO_BITS-1:0]   base_cur;
    logic [QUO_BITS-1:0]   base_new;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS-1:0]  high_time;
    logic                  lock_hit;
    logic [QUO_BITS:0]     angle_sum;
    logic [ANGLE_BITS-1:0] angle_sat;
    logic                  div_start;
    logic                  div_done;
    logic [QUO_BITS-1:0]   div_quo;
    logic                  out_free;
    t_coils                win_coils;

    assign fall_edge  = r_last && !r_lvl;
    assign rise_edge  = !r_last && r_lvl;
    assign tooth_inc  = r_tooth + 1'b1;
    assign tooth_wrap = (tooth_inc == TOOTH_BITS'(TEETH_PER_REV));
    assign tooth_next = tooth_wrap ? '0 : tooth_inc;
    assign half_next  = r_half ^ tooth_wrap;
    assign base_cur   = base_angle(r_half, r_tooth);
    assign base_new   = base_angle(half_next, tooth_next);
    assign gap        = r_now - r_fall;
    assign high_time  = r_fall - r_rise;
    assign lock_hit   = (r_rise != '0) && (r_fall != '0)
                      && ({1'b0, gap} > {high_time, 1'b0});
    assign angle_sum  = {1'b0, r_base} + {1'b0, div_quo};
    assign angle_sat  = (angle_sum > (QUO_BITS + 1)'(ANGLE_MAX)) ? ANGLE_MAX
                      : angle_sum[ANGLE_BITS-1:0];
    assign out_free   = !r_out_valid || o_res.ready;

    cad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    cad_win u_win (
        .i_angle (r_angle),
        .o_coils (win_coils)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_locked) begin
                    n_state = ST_FIN;
                end else if (fall_edge || rise_edge) begin
                    n_state = ST_WIN;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_WIN;
            ST_WIN:  n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_smp.ready = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: i_smp.ready = 1'b1;
            ST_LOAD: div_start   = 1'b1;
            default: begin
                i_smp.ready = 1'b0;
                div_start   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_locked <= 1'b0;
            r_last   <= 1'b0;
            r_tooth  <= '0;
            r_half   <= 1'b0;
            r_rise   <= '0;
            r_fall   <= '0;
            r_angle  <= '0;
            r_coil   <= '0;
            r_marker <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_EVAL: begin
                    if (!r_locked) begin
                        r_marker <= 1'b0;
                        if (fall_edge) begin
                            r_last <= 1'b0;
                            r_fall <= r_now;
                        end else if (rise_edge) begin
                            r_last <= 1'b1;
                            r_rise <= r_now;
                            if (lock_hit) begin
                                r_locked <= 1'b1;
                                r_angle  <= '0;
                                r_tooth  <= '0;
                            end
                        end
                    end else if (fall_edge) begin
                        r_last  <= 1'b0;
                        r_fall  <= r_now;
                        r_angle <= ANGLE_BITS'(base_cur + QUO_BITS'(HALF_SPAN));
                    end else if (rise_edge) begin
                        r_last  <= 1'b1;
                        r_rise  <= r_now;
                        r_tooth <= tooth_next;
                        r_half  <= half_next;
                        r_angle <= ANGLE_BITS'(base_new);
                    end
                end
                ST_SUM: r_angle <= angle_sat;
                ST_WIN: begin
                    r_coil   <= win_coils;
                    r_marker <= (r_angle == '0);
                end
                default: r_last <= r_last;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_smp.valid) begin
            r_now <= i_smp.sample_time;
            r_lvl <= i_smp.sensor_level;
        end
        if (r_state == ST_EVAL) begin
            if (r_rise > r_fall) begin
                r_num  <= r_now - r_rise;
                r_den  <= r_rise - r_fall;
                r_base <= base_cur;
            end else begin
                r_num  <= r_now - r_fall;
                r_den  <= r_fall - r_rise;
                r_base <= base_cur + QUO_BITS'(HALF_SPAN);
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_BITS'(r_num) * PROD_BITS'(HALF_SPAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_angle  <= r_angle;
            r_out_coil   <= r_coil;
            r_out_locked <= r_locked;
            r_out_marker <= r_marker;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.angle       = r_out_angle;
    assign o_res.coil_one    = r_out_coil[0];
    assign o_res.coil_two    = r_out_coil[1];
    assign o_res.coil_three  = r_out_coil[2];
    assign o_res.coil_four   = r_out_coil[3];
    assign o_res.locked      = r_out_locked;
    assign o_res.zero_marker = r_out_marker;

endmodule

// ===== tb/crank_angle_decoder_ignition_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crank angle decoder testbench
// Drives timestamped sensor samples into the decoder and checks every result
// word against an angle predictor kept in a small scoreboard. A directed part
// walks the lock search, edge angles, interpolation, a zero divisor and
// saturation. Random trigger wheel rotations with noise and time wrap follow,
// under phases of sender idling, receiver stalls and one long receiver stall.
// ----------------------------------------------------------------------------
module crank_angle_decoder_ignition_tb;
    import cad_pkg::*;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        t_coils                coils;
        logic                  locked;
        logic                  marker;
    } t_angle_word;

    class angle_scoreboard;
        t_angle_word pending_angles[$];
        int          mismatches;
        int          results_seen;
        int          locked_steps;
        int          zero_marks;
        int          saturations;
        int          coil_hits[COIL_COUNT];

        logic                  is_locked;
        logic                  last_level;
        logic                  half_cycle;
        logic [TOOTH_BITS-1:0] tooth;
        logic [TIME_BITS-1:0]  rise_t;
        logic [TIME_BITS-1:0]  fall_t;
        logic [ANGLE_BITS-1:0] angle;
        t_coils                coils;

        function new();
            is_locked  = 1'b0;
            last_level = 1'b0;
            half_cycle = 1'b0;
            tooth      = '0;
            rise_t     = '0;
            fall_t     = '0;
            angle      = '0;
            coils      = '0;
        endfunction

        function logic [63:0] tooth_start();
            return (half_cycle ? 64'(REV_SPAN) : 64'd0) + 64'(tooth) * 64'(TOOTH_SPAN);
        endfunction

        function logic [63:0] half_tooth_offset(logic [TIME_BITS-1:0] elapsed,
                                                logic [TIME_BITS-1:0] span);
            if (span == '0) return 64'd0;
            return (64'(elapsed) * 64'(HALF_SPAN)) / 64'(span);
        endfunction

        function void note_sample(logic [TIME_BITS-1:0] now, logic lvl);
            logic [63:0]          a;
            logic [TIME_BITS-1:0] gap;
            logic [TIME_BITS-1:0] high;
            t_angle_word          w;
            w.marker = 1'b0;
            if (is_locked) begin
                if (last_level && !lvl) begin
                    last_level = 1'b0;
                    fall_t     = now;
                    a          = tooth_start() + 64'(HALF_SPAN);
                end else if (!last_level && lvl) begin
                    last_level = 1'b1;
                    rise_t     = now;
                    tooth      = TOOTH_BITS'(tooth + 1);
                    if (tooth == TEETH_PER_REV) begin
                        tooth      = '0;
                        half_cycle = ~half_cycle;
                    end
                    a = tooth_start();
                end else if (rise_t > fall_t) begin
                    a = tooth_start() + half_tooth_offset(now - rise_t, rise_t - fall_t);
                end else begin
                    a = tooth_start() + 64'(HALF_SPAN)
                        + half_tooth_offset(now - fall_t, fall_t - rise_t);
                end
                if (a >= 64'(ANGLE_MAX)) saturations++;
                angle    = (a > 64'(ANGLE_MAX)) ? ANGLE_MAX : a[ANGLE_BITS-1:0];
                coils[0] = angle <= WIN_ONE_HI;
                coils[1] = angle >= WIN_TWO_LO && angle <= WIN_TWO_HI;
                coils[2] = angle >= WIN_THREE_LO && angle <= WIN_THREE_HI;
                coils[3] = angle >= WIN_FOUR_LO && angle <= WIN_FOUR_HI;
                w.marker = angle == '0;
                locked_steps++;
                if (w.marker) zero_marks++;
                for (int i = 0; i < COIL_COUNT; i++) if (coils[i]) coil_hits[i]++;
            end else begin
                if (last_level && !lvl) begin
                    last_level = 1'b0;
                    fall_t     = now;
                end else if (!last_level && lvl) begin
                    last_level = 1'b1;
                    gap        = now - fall_t;
                    high       = fall_t - rise_t;
                    if (rise_t != '0 && fall_t != '0 && {1'b0, gap} > {high, 1'b0}) begin
                        angle     = '0;
                        is_locked = 1'b1;
                        tooth     = '0;
                    end
                    rise_t = now;
                end
            end
            w.angle  = angle;
            w.coils  = coils;
            w.locked = is_locked;
            pending_angles.push_back(w);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_angle_word got);
            t_angle_word want;
            results_seen++;
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, angle %0d",
                                          got.angle));
            end else begin
                want = pending_angles.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch($sformatf("angle %0d, expected %0d",
                                              got.angle, want.angle));
                if (got.coils !== want.coils)
                    report_mismatch($sformatf("coils %b, expected %b at angle %0d",
                                              got.coils, want.coils, want.angle));
                if (got.locked !== want.locked)
                    report_mismatch($sformatf("locked %b, expected %b",
                                              got.locked, want.locked));
                if (got.marker !== want.marker)
                    report_mismatch($sformatf("zero marker %b, expected %b at angle %0d",
                                              got.marker, want.marker, want.angle));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    cad_in_if  smp_if();
    cad_out_if res_if();

    crank_angle_decoder_ignition uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    angle_scoreboard      sb = new();
    int                   snd_idle_pct;
    int                   rcv_stall_pct;
    int                   rcv_hold_cycles;
    int                   samples_sent;
    logic [TIME_BITS-1:0] wheel_time;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d result words outstanding", sb.pending_angles.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic offer_sample(logic [TIME_BITS-1:0] ts, logic lvl);
        while ($urandom_range(99) < snd_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.sample_time  <= ts;
        smp_if.sensor_level <= lvl;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        sb.note_sample(ts, lvl);
        samples_sent++;
    endtask

    function automatic int unsigned pick_phase_len();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 4) return 0;
        if (k < 10) return $urandom_range(3, 1);
        if (k < 16) return $urandom_range(200000, 5000);
        return $urandom_range(2000, 20);
    endfunction

    task automatic spin_wheel(int target);
        int          first;
        int unsigned kind;
        int unsigned hi_len;
        int unsigned lo_len;
        first = samples_sent;
        while (samples_sent - first < target) begin
            kind = $urandom_range(99);
            if (kind < 86) begin
                hi_len = pick_phase_len();
                lo_len = pick_phase_len();
                if ($urandom_range(35) == 0) lo_len = lo_len * 3;
                offer_sample(wheel_time, 1'b1);
                repeat ($urandom_range(2))
                    offer_sample(wheel_time + $urandom_range(hi_len + hi_len / 3), 1'b1);
                wheel_time = wheel_time + hi_len;
                offer_sample(wheel_time, 1'b0);
                repeat ($urandom_range(2))
                    offer_sample(wheel_time + $urandom_range(lo_len + lo_len / 3), 1'b0);
                wheel_time = wheel_time + lo_len;
            end else if (kind < 96) begin
                wheel_time = wheel_time + $urandom_range(500);
                offer_sample(wheel_time, 1'($urandom_range(1)));
            end else begin
                wheel_time = $urandom();
                offer_sample(wheel_time, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        t_angle_word w;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                w.angle  = res_if.angle;
                w.coils  = {res_if.coil_four, res_if.coil_three,
                            res_if.coil_two, res_if.coil_one};
                w.locked = res_if.locked;
                w.marker = res_if.zero_marker;
                sb.check_result(w);
            end
            if (rcv_hold_cycles > 0) begin
                rcv_hold_cycles--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= $urandom_range(99) >= rcv_stall_pct;
            end
        end
    end

    initial begin
        snd_idle_pct        = 0;
        rcv_stall_pct       = 0;
        rcv_hold_cycles     = 0;
        samples_sent        = 0;
        rst_n               <= 1'b0;
        smp_if.valid        <= 1'b0;
        smp_if.sample_time  <= '0;
        smp_if.sensor_level <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lock search: a rise with no stored rise time, a gap of exactly twice
        // the high time, then a gap one longer that locks.
        offer_sample(32'd0, 1'b0);
        offer_sample(32'd0, 1'b1);
        offer_sample(32'd50, 1'b0);
        offer_sample(32'd1000, 1'b1);
        offer_sample(32'd1000, 1'b1);
        offer_sample(32'd1010, 1'b0);
        offer_sample(32'd1030, 1'b1);
        offer_sample(32'd1040, 1'b0);
        offer_sample(32'd1061, 1'b1);
        // Interpolation at zero, within and beyond the tooth, edges at equal
        // times giving a zero divisor, and a saturating angle.
        offer_sample(32'd1061, 1'b1);
        offer_sample(32'd1071, 1'b1);
        offer_sample(32'd1200, 1'b1);
        offer_sample(32'd1300, 1'b0);
        offer_sample(32'd1300, 1'b1);
        offer_sample(32'd1350, 1'b1);
        offer_sample(32'd1360, 1'b0);
        offer_sample(32'd1390, 1'b0);
        offer_sample(32'hFFFF_FFFF, 1'b0);

        wheel_time      = 32'hFFFF_FFFF - $urandom_range(300000);
        rcv_hold_cycles = 400;
        spin_wheel(500);
        snd_idle_pct = 55;
        spin_wheel(450);
        snd_idle_pct  = 0;
        rcv_stall_pct = 55;
        spin_wheel(450);
        snd_idle_pct  = 14;
        rcv_stall_pct = 14;
        spin_wheel(450);
        smp_if.valid <= 1'b0;

        while (sb.pending_angles.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d result words for %0d samples, %0d of them after lock.",
                 sb.results_seen, samples_sent, sb.locked_steps);
        $display("Zero markers %0d, saturated angles %0d, coil windows hit %0d/%0d/%0d/%0d.",
                 sb.zero_marks, sb.saturations, sb.coil_hits[0], sb.coil_hits[1],
                 sb.coil_hits[2], sb.coil_hits[3]);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
